FILE: design/csc_pkg.sv
// Shared types and constants of the speed and cadence decoder.
// No dependencies; used by the parser and the top level.
package csc_pkg;

  localparam int unsigned CircW     = 12;
  localparam int unsigned WheelCntW = 32;
  localparam int unsigned TimeW     = 16;
  localparam int unsigned CrankCntW = 16;
  localparam int unsigned ResW      = 16;

  // speed = dw * (circ * 9) * 2^10 / (25 * tw)
  localparam int unsigned SpdMulBW  = 16;
  localparam int unsigned SpdShift  = 10;
  localparam int unsigned SpdNumW   = WheelCntW + SpdMulBW + SpdShift;
  localparam int unsigned SpdDenW   = TimeW + 5;

  // cadence = dc * 375 * 2^14 / tc
  localparam int unsigned CadMulBW  = 9;
  localparam int unsigned CadShift  = 14;
  localparam int unsigned CadNumW   = CrankCntW + CadMulBW + CadShift;
  localparam int unsigned CadDenW   = TimeW;
  localparam logic [CadMulBW-1:0] CadFactor = 9'd375;

  typedef struct packed {
    logic                 pkt_short;
    logic [WheelCntW-1:0] dw;
    logic [TimeW-1:0]     tw;
    logic [CrankCntW-1:0] dc;
    logic [TimeW-1:0]     tc;
  } job_t;

endpackage

FILE: design/csc_parse.sv
// Byte parser: assembles wheel and crank fields and forms deltas on the last byte.
// Depends on csc_pkg.
module csc_parse (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          take_i,
  input  logic [7:0]    data_byte_i,
  input  logic          first_byte_i,
  input  logic          last_byte_i,
  output logic          job_valid_o,
  output csc_pkg::job_t job_o
);

  logic [3:0]  pos_q, pos_d;
  logic [1:0]  flags_q, flags_d;
  logic [csc_pkg::WheelCntW-1:0] wc_q, wc_d, wcb_q, wcb_d;
  logic [csc_pkg::TimeW-1:0]     wt_q, wt_d, wtb_q, wtb_d;
  logic [csc_pkg::CrankCntW-1:0] cc_q, cc_d, ccb_q, ccb_d;
  logic [csc_pkg::TimeW-1:0]     ct_q, ct_d, ctb_q, ctb_d;

  always_comb begin
    logic [3:0] p;
    logic [3:0] base;
    logic [3:0] off;
    logic [3:0] needed;
    logic [3:0] got;
    logic       open;
    logic       in_wheel;
    pos_d = pos_q;
    flags_d = flags_q;
    wc_d = wc_q;  wt_d = wt_q;  cc_d = cc_q;  ct_d = ct_q;
    wcb_d = wcb_q; wtb_d = wtb_q; ccb_d = ccb_q; ctb_d = ctb_q;
    job_valid_o = 1'b0;
    job_o = '0;
    p = pos_q - 4'd1;
    base = 4'd0;
    off = 4'd0;
    needed = 4'd0;
    got = 4'd0;
    open = 1'b0;
    in_wheel = 1'b0;
    if (take_i) begin
      if (first_byte_i) begin
        if (pos_q != 4'd0) begin
          // drop the open packet
          wc_d = wcb_q; wt_d = wtb_q; cc_d = ccb_q; ct_d = ctb_q;
        end
        flags_d = data_byte_i[1:0];
        pos_d = 4'd1;
        open = 1'b1;
      end else if (pos_q != 4'd0) begin
        open = 1'b1;
        if (flags_q[0]) begin
          base = 4'd6;
          if (p < 4'd4) begin
            wc_d[{p[1:0], 3'b000} +: 8] = data_byte_i;
            in_wheel = 1'b1;
          end else if (p < 4'd6) begin
            wt_d[{p[0], 3'b000} +: 8] = data_byte_i;
            in_wheel = 1'b1;
          end
        end
        off = p - base;
        if (flags_q[1] && !in_wheel && p >= base) begin
          if (off < 4'd2) begin
            cc_d[{off[0], 3'b000} +: 8] = data_byte_i;
          end else if (off < 4'd4) begin
            ct_d[{off[0], 3'b000} +: 8] = data_byte_i;
          end
        end
        if (pos_q != 4'd15) begin
          pos_d = pos_q + 4'd1;
        end
      end

      if (open && last_byte_i) begin
        needed = (flags_d[0] ? 4'd6 : 4'd0) + (flags_d[1] ? 4'd4 : 4'd0);
        got = pos_d - 4'd1;
        job_valid_o = 1'b1;
        if (got < needed) begin
          job_o.pkt_short = 1'b1;
          wc_d = wcb_q; wt_d = wtb_q; cc_d = ccb_q; ct_d = ctb_q;
        end else begin
          job_o.dw = wc_d - wcb_q;
          job_o.tw = wt_d - wtb_q;
          job_o.dc = cc_d - ccb_q;
          job_o.tc = ct_d - ctb_q;
          wcb_d = wc_d; wtb_d = wt_d; ccb_d = cc_d; ctb_d = ct_d;
        end
        pos_d = 4'd0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
      flags_q <= '0;
      wc_q <= '0;  wt_q <= '0;  cc_q <= '0;  ct_q <= '0;
      wcb_q <= '0; wtb_q <= '0; ccb_q <= '0; ctb_q <= '0;
    end else begin
      pos_q <= pos_d;
      flags_q <= flags_d;
      wc_q <= wc_d;   wt_q <= wt_d;   cc_q <= cc_d;   ct_q <= ct_d;
      wcb_q <= wcb_d; wtb_q <= wtb_d; ccb_q <= ccb_d; ctb_q <= ctb_d;
    end
  end

endmodule

FILE: design/csc_mul.sv
// Bit-serial shift-add multiplier, one multiplier bit per cycle, LSB first.
// No dependencies.
module csc_mul #(
  parameter int unsigned AW = 32,
  parameter int unsigned BW = 16
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [AW-1:0]    a_i,
  input  logic [BW-1:0]    b_i,
  output logic             busy_o,
  output logic [AW+BW-1:0] prod_o
);

  localparam int unsigned CW = $clog2(BW + 1);

  logic [CW-1:0]    cnt_q, cnt_d;
  logic [AW-1:0]    a_q, a_d;
  logic [AW+BW-1:0] p_q, p_d;
  logic [AW:0]      sum;

  always_comb begin
    sum = {1'b0, p_q[AW+BW-1:BW]} + (p_q[0] ? {1'b0, a_q} : '0);
    cnt_d = cnt_q;
    a_d = a_q;
    p_d = p_q;
    if (start_i) begin
      cnt_d = CW'(BW);
      a_d = a_i;
      p_d = {{AW{1'b0}}, b_i};
    end else if (cnt_q != '0) begin
      cnt_d = cnt_q - 1'b1;
      p_d = {sum, p_q[BW-1:1]};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q <= a_d;
    p_q <= p_d;
  end

  assign busy_o = (cnt_q != '0);
  assign prod_o = p_q;

endmodule

FILE: design/csc_div.sv
// Bit-serial restoring divider with a quotient saturated to QW bits.
// No dependencies.
module csc_div #(
  parameter int unsigned NW = 58,
  parameter int unsigned DW = 21,
  parameter int unsigned QW = 16
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [NW-1:0] num_i,
  input  logic [DW-1:0] den_i,
  output logic          busy_o,
  output logic [QW-1:0] quot_o
);

  localparam int unsigned CW = $clog2(NW + 1);

  logic [CW-1:0] cnt_q, cnt_d;
  logic [NW-1:0] n_q, n_d;
  logic [DW-1:0] den_q, den_d;
  logic [DW-1:0] r_q, r_d;
  logic [QW-1:0] q_q, q_d;
  logic          sat_q, sat_d;
  logic [DW:0]   trial;
  logic          ge;

  always_comb begin
    trial = {r_q, n_q[NW-1]};
    ge = (trial >= {1'b0, den_q});
    cnt_d = cnt_q;
    n_d = n_q;
    den_d = den_q;
    r_d = r_q;
    q_d = q_q;
    sat_d = sat_q;
    if (start_i) begin
      cnt_d = CW'(NW);
      n_d = num_i;
      den_d = den_i;
      r_d = '0;
      q_d = '0;
      sat_d = 1'b0;
    end else if (cnt_q != '0) begin
      cnt_d = cnt_q - 1'b1;
      n_d = {n_q[NW-2:0], 1'b0};
      r_d = ge ? DW'(trial - {1'b0, den_q}) : DW'(trial);
      q_d = {q_q[QW-2:0], ge};
      // a set bit above the result width overflows it
      if (ge && cnt_q > CW'(QW)) begin
        sat_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    n_q <= n_d;
    den_q <= den_d;
    r_q <= r_d;
    q_q <= q_d;
    sat_q <= sat_d;
  end

  assign busy_o = (cnt_q != '0);
  assign quot_o = sat_q ? {QW{1'b1}} : q_q;

endmodule

FILE: design/csc_speed_cadence_decoder.sv
// Cycling speed and cadence notification decoder, top level.
// Uses csc_pkg, csc_parse, csc_mul and csc_div.
//
// Notification bytes are taken one per cycle while the block is idle; a byte
// that is not the last one does not stall the input. On the last byte of a
// complete packet the block runs bit-serial multipliers, then bit-serial
// dividers, of which the 58-step speed divider is the longer, and stalls the
// input until the result enters the output register. A packet that ends short
// skips the arithmetic and passes through the done state into that register.
// Every result waits in the output register until taken; bytes are accepted
// meanwhile unless arithmetic is in progress or a result waits in the done state.
module csc_speed_cadence_decoder (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [csc_pkg::CircW-1:0]   cfg_wdata_i,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [7:0]                  data_byte_i,
  input  logic                        first_byte_i,
  input  logic                        last_byte_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [csc_pkg::ResW-1:0]    speed_centi_kmh_o,
  output logic [csc_pkg::ResW-1:0]    cadence_centi_rpm_o,
  output logic                        speed_updated_o,
  output logic                        cadence_updated_o,
  output logic                        packet_short_o
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_MUL  = 2'd1;
  localparam logic [1:0] S_DIV  = 2'd2;
  localparam logic [1:0] S_DONE = 2'd3;

  logic [1:0] state_q, state_d;
  logic [csc_pkg::CircW-1:0] circ_q;
  logic [csc_pkg::SpdMulBW-1:0] circ9;

  logic          take;
  logic          job_valid;
  csc_pkg::job_t job;
  logic          job_start;

  logic spd_en_q, spd_en_d, cad_en_q, cad_en_d, short_q, short_d;
  logic [csc_pkg::SpdDenW-1:0] spd_den_q, spd_den_d;
  logic [csc_pkg::CadDenW-1:0] cad_den_q, cad_den_d;

  logic mul_spd_busy, mul_cad_busy, div_spd_busy, div_cad_busy;
  logic div_start;
  logic [csc_pkg::WheelCntW+csc_pkg::SpdMulBW-1:0] spd_prod;
  logic [csc_pkg::CrankCntW+csc_pkg::CadMulBW-1:0] cad_prod;
  logic [csc_pkg::ResW-1:0] spd_quot, cad_quot;

  logic out_valid_q, out_valid_d;
  logic [csc_pkg::ResW-1:0] speed_q, speed_d, cadence_q, cadence_d;
  logic spd_upd_q, spd_upd_d, cad_upd_q, cad_upd_d, pshort_q, pshort_d;

  assign take = in_valid_i && in_ready_o;
  assign in_ready_o = (state_q == S_IDLE);
  assign circ9 = {4'b0000, circ_q} + {1'b0, circ_q, 3'b000};
  assign job_start = job_valid && !job.pkt_short;

  csc_parse u_parse (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .take_i       (take),
    .data_byte_i  (data_byte_i),
    .first_byte_i (first_byte_i),
    .last_byte_i  (last_byte_i),
    .job_valid_o  (job_valid),
    .job_o        (job)
  );

  csc_mul #(
    .AW (csc_pkg::WheelCntW),
    .BW (csc_pkg::SpdMulBW)
  ) u_mul_spd (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (job_start),
    .a_i     (job.dw),
    .b_i     (circ9),
    .busy_o  (mul_spd_busy),
    .prod_o  (spd_prod)
  );

  csc_mul #(
    .AW (csc_pkg::CrankCntW),
    .BW (csc_pkg::CadMulBW)
  ) u_mul_cad (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (job_start),
    .a_i     (job.dc),
    .b_i     (csc_pkg::CadFactor),
    .busy_o  (mul_cad_busy),
    .prod_o  (cad_prod)
  );

  csc_div #(
    .NW (csc_pkg::SpdNumW),
    .DW (csc_pkg::SpdDenW),
    .QW (csc_pkg::ResW)
  ) u_div_spd (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   ({spd_prod, {csc_pkg::SpdShift{1'b0}}}),
    .den_i   (spd_den_q),
    .busy_o  (div_spd_busy),
    .quot_o  (spd_quot)
  );

  csc_div #(
    .NW (csc_pkg::CadNumW),
    .DW (csc_pkg::CadDenW),
    .QW (csc_pkg::ResW)
  ) u_div_cad (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   ({cad_prod, {csc_pkg::CadShift{1'b0}}}),
    .den_i   (cad_den_q),
    .busy_o  (div_cad_busy),
    .quot_o  (cad_quot)
  );

  always_comb begin
    state_d = state_q;
    spd_en_d = spd_en_q;
    cad_en_d = cad_en_q;
    short_d = short_q;
    spd_den_d = spd_den_q;
    cad_den_d = cad_den_q;
    div_start = 1'b0;
    out_valid_d = out_valid_q;
    speed_d = speed_q;
    cadence_d = cadence_q;
    spd_upd_d = spd_upd_q;
    cad_upd_d = cad_upd_q;
    pshort_d = pshort_q;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        if (job_valid) begin
          short_d = job.pkt_short;
          spd_en_d = !job.pkt_short && (circ_q != '0) && (job.tw != '0);
          cad_en_d = !job.pkt_short && (job.tc != '0);
          spd_den_d = {1'b0, job.tw, 4'b0000} + {2'b00, job.tw, 3'b000}
                    + {5'b00000, job.tw};
          cad_den_d = job.tc;
          state_d = job.pkt_short ? S_DONE : S_MUL;
        end
      end
      S_MUL: begin
        if (!mul_spd_busy && !mul_cad_busy) begin
          div_start = 1'b1;
          state_d = S_DIV;
        end
      end
      S_DIV: begin
        if (!div_spd_busy && !div_cad_busy) begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        // hold until the output register is free
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          if (spd_en_q) begin
            speed_d = spd_quot;
          end
          if (cad_en_q) begin
            cadence_d = cad_quot;
          end
          spd_upd_d = spd_en_q;
          cad_upd_d = cad_en_q;
          pshort_d = short_q;
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      circ_q <= '0;
      out_valid_q <= 1'b0;
      speed_q <= '0;
      cadence_q <= '0;
      spd_upd_q <= 1'b0;
      cad_upd_q <= 1'b0;
      pshort_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        circ_q <= cfg_wdata_i;
      end
      out_valid_q <= out_valid_d;
      speed_q <= speed_d;
      cadence_q <= cadence_d;
      spd_upd_q <= spd_upd_d;
      cad_upd_q <= cad_upd_d;
      pshort_q <= pshort_d;
    end
  end

  always_ff @(posedge clk_i) begin
    spd_en_q <= spd_en_d;
    cad_en_q <= cad_en_d;
    short_q <= short_d;
    spd_den_q <= spd_den_d;
    cad_den_q <= cad_den_d;
  end

  assign out_valid_o = out_valid_q;
  assign speed_centi_kmh_o = speed_q;
  assign cadence_centi_rpm_o = cadence_q;
  assign speed_updated_o = spd_upd_q;
  assign cadence_updated_o = cad_upd_q;
  assign packet_short_o = pshort_q;

  a_short_no_update: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && packet_short_o |-> !speed_updated_o && !cadence_updated_o)
    else $error("short packet reported an update");

  a_job_when_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    job_valid |-> state_q == S_IDLE)
    else $error("packet finished while arithmetic in progress");

  a_div_after_mul: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_DIV |-> !mul_spd_busy && !mul_cad_busy)
    else $error("division running while multiply is busy");

  a_mul_started: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_IDLE && state_d == S_MUL |=> mul_spd_busy && mul_cad_busy)
    else $error("multipliers did not start");

endmodule

FILE: tb/csc_speed_cadence_decoder_chk.sv
`timescale 1ns / 1ps
// Scoreboard for the speed and cadence decoder: rebuilds each reading from the
// accepted notification bytes and the circumference register, then compares.
// Depends on csc_pkg for the field widths.
module csc_speed_cadence_decoder_chk (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [csc_pkg::CircW-1:0] cfg_wdata_i,
  input  logic                      in_valid_i,
  input  logic                      in_ready_i,
  input  logic [7:0]                data_byte_i,
  input  logic                      first_byte_i,
  input  logic                      last_byte_i,
  input  logic                      out_valid_i,
  input  logic                      out_ready_i,
  input  logic [csc_pkg::ResW-1:0]  speed_centi_kmh_i,
  input  logic [csc_pkg::ResW-1:0]  cadence_centi_rpm_i,
  input  logic                      speed_updated_i,
  input  logic                      cadence_updated_i,
  input  logic                      packet_short_i,
  output int                        fail_count_o,
  output int                        pending_o
);

  typedef struct packed {
    logic [csc_pkg::ResW-1:0] speed;
    logic [csc_pkg::ResW-1:0] cadence;
    logic                     speed_upd;
    logic                     cadence_upd;
    logic                     pkt_short;
  } reading_t;

  reading_t expected_readings[$];
  reading_t exp_r;
  int       n_err;

  logic [csc_pkg::CircW-1:0]     circ_mm;
  logic [3:0]                    rx_pos;
  logic [1:0]                    rx_flags;
  logic [csc_pkg::WheelCntW-1:0] wheel_revs_rx, wheel_revs_ref;
  logic [csc_pkg::TimeW-1:0]     wheel_evt_rx, wheel_evt_ref;
  logic [csc_pkg::CrankCntW-1:0] crank_revs_rx, crank_revs_ref;
  logic [csc_pkg::TimeW-1:0]     crank_evt_rx, crank_evt_ref;
  logic [csc_pkg::ResW-1:0]      speed_last, cadence_last;

  function automatic void restore_rx();
    wheel_revs_rx = wheel_revs_ref;
    wheel_evt_rx  = wheel_evt_ref;
    crank_revs_rx = crank_revs_ref;
    crank_evt_rx  = crank_evt_ref;
  endfunction

  function automatic void check_field(input string name, input int unsigned want,
                                      input int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
      n_err++;
    end
  endfunction

  task automatic decode_byte(input logic [7:0] b, input logic is_first, input logic is_last);
    int unsigned                   p;
    int unsigned                   crank_base;
    int unsigned                   need;
    logic [csc_pkg::WheelCntW-1:0] dw;
    logic [csc_pkg::TimeW-1:0]     tw;
    logic [csc_pkg::CrankCntW-1:0] dc;
    logic [csc_pkg::TimeW-1:0]     tc;
    logic [63:0]                   num;
    logic [63:0]                   quo;
    reading_t                      r;
    crank_base = 0;
    if (is_first) begin
      // a flags byte inside an open packet drops that packet
      if (rx_pos != 0) restore_rx();
      rx_flags = b[1:0];
      rx_pos = 1;
    end else if (rx_pos == 0) begin
      return;
    end else begin
      p = rx_pos - 1;
      if (rx_flags[0] && p < 4) begin
        wheel_revs_rx[8*p +: 8] = b;
      end else if (rx_flags[0] && p < 6) begin
        wheel_evt_rx[8*(p-4) +: 8] = b;
      end else begin
        if (rx_flags[0]) crank_base = 6;
        if (rx_flags[1] && p >= crank_base && p < crank_base + 2)
          crank_revs_rx[8*(p-crank_base) +: 8] = b;
        else if (rx_flags[1] && p >= crank_base + 2 && p < crank_base + 4)
          crank_evt_rx[8*(p-crank_base-2) +: 8] = b;
      end
      if (rx_pos < 15) rx_pos++;
    end
    if (!is_last) return;

    r = '0;
    need = (rx_flags[0] ? 6 : 0) + (rx_flags[1] ? 4 : 0);
    if (rx_pos <= need) begin
      r.pkt_short = 1'b1;
      restore_rx();
    end else begin
      dw = wheel_revs_rx - wheel_revs_ref;
      tw = wheel_evt_rx - wheel_evt_ref;
      dc = crank_revs_rx - crank_revs_ref;
      tc = crank_evt_rx - crank_evt_ref;
      if (circ_mm != 0 && tw != 0) begin
        num = dw * circ_mm * 64'd9216;
        quo = num / (tw * 64'd25);
        speed_last = (quo > 64'hFFFF) ? '1 : quo[csc_pkg::ResW-1:0];
        r.speed_upd = 1'b1;
      end
      if (tc != 0) begin
        num = dc * 64'd6144000;
        quo = num / tc;
        cadence_last = (quo > 64'hFFFF) ? '1 : quo[csc_pkg::ResW-1:0];
        r.cadence_upd = 1'b1;
      end
      wheel_revs_ref = wheel_revs_rx;
      wheel_evt_ref  = wheel_evt_rx;
      crank_revs_ref = crank_revs_rx;
      crank_evt_ref  = crank_evt_rx;
    end
    rx_pos = 0;
    r.speed = speed_last;
    r.cadence = cadence_last;
    expected_readings.push_back(r);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      circ_mm = '0;
      rx_pos = '0;
      rx_flags = '0;
      wheel_revs_rx = '0;
      wheel_evt_rx = '0;
      crank_revs_rx = '0;
      crank_evt_rx = '0;
      wheel_revs_ref = '0;
      wheel_evt_ref = '0;
      crank_revs_ref = '0;
      crank_evt_ref = '0;
      speed_last = '0;
      cadence_last = '0;
      expected_readings.delete();
      n_err = 0;
      fail_count_o <= 0;
      pending_o <= 0;
    end else begin
      if (cfg_we_i) circ_mm = cfg_wdata_i;
      // compare before decoding: a reading never leaves in its own byte's cycle
      if (out_valid_i && out_ready_i) begin
        if (expected_readings.size() == 0) begin
          $display("%0t: reading with none expected, got speed %0d cadence %0d",
                   $time, speed_centi_kmh_i, cadence_centi_rpm_i);
          n_err++;
        end else begin
          exp_r = expected_readings.pop_front();
          check_field("speed_centi_kmh", exp_r.speed, speed_centi_kmh_i);
          check_field("cadence_centi_rpm", exp_r.cadence, cadence_centi_rpm_i);
          check_field("speed_updated", exp_r.speed_upd, speed_updated_i);
          check_field("cadence_updated", exp_r.cadence_upd, cadence_updated_i);
          check_field("packet_short", exp_r.pkt_short, packet_short_i);
        end
      end
      if (in_valid_i && in_ready_i) decode_byte(data_byte_i, first_byte_i, last_byte_i);
      fail_count_o <= n_err;
      pending_o <= expected_readings.size();
    end
  end

endmodule

FILE: tb/csc_speed_cadence_decoder_tb.sv
`timescale 1ns / 1ps
// Top of the speed and cadence decoder testbench: clock, reset, notification
// traffic, result back-pressure and the verdict. Uses csc_pkg and the checker.
module csc_speed_cadence_decoder_tb;

  localparam int unsigned WatchdogLimit = 4000;
  localparam int unsigned SettleCycles  = 120;
  localparam int unsigned PhaseBytes    = 140;

  logic                      clk_i = 1'b0;
  logic                      rst_ni = 1'b0;
  logic                      cfg_we_i = 1'b0;
  logic [csc_pkg::CircW-1:0] cfg_wdata_i = '0;
  logic                      in_valid_i = 1'b0;
  logic                      in_ready_o;
  logic [7:0]                data_byte_i = '0;
  logic                      first_byte_i = 1'b0;
  logic                      last_byte_i = 1'b0;
  logic                      out_valid_o;
  logic                      out_ready_i = 1'b0;
  logic [csc_pkg::ResW-1:0]  speed_centi_kmh_o;
  logic [csc_pkg::ResW-1:0]  cadence_centi_rpm_o;
  logic                      speed_updated_o;
  logic                      cadence_updated_o;
  logic                      packet_short_o;

  int fail_count;
  int pending;
  int stall_cycles = 0;
  int sent_bytes = 0;
  bit in_idle = 1'b1;
  bit out_idle = 1'b1;

  // sensor values carried into the next notification
  logic [csc_pkg::WheelCntW-1:0] wheel_revs = '0;
  logic [csc_pkg::TimeW-1:0]     wheel_evt = '0;
  logic [csc_pkg::CrankCntW-1:0] crank_revs = '0;
  logic [csc_pkg::TimeW-1:0]     crank_evt = '0;

  csc_speed_cadence_decoder dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_we_i           (cfg_we_i),
    .cfg_wdata_i        (cfg_wdata_i),
    .in_valid_i         (in_valid_i),
    .in_ready_o         (in_ready_o),
    .data_byte_i        (data_byte_i),
    .first_byte_i       (first_byte_i),
    .last_byte_i        (last_byte_i),
    .out_valid_o        (out_valid_o),
    .out_ready_i        (out_ready_i),
    .speed_centi_kmh_o  (speed_centi_kmh_o),
    .cadence_centi_rpm_o(cadence_centi_rpm_o),
    .speed_updated_o    (speed_updated_o),
    .cadence_updated_o  (cadence_updated_o),
    .packet_short_o     (packet_short_o)
  );

  csc_speed_cadence_decoder_chk u_chk (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_we_i           (cfg_we_i),
    .cfg_wdata_i        (cfg_wdata_i),
    .in_valid_i         (in_valid_i),
    .in_ready_i         (in_ready_o),
    .data_byte_i        (data_byte_i),
    .first_byte_i       (first_byte_i),
    .last_byte_i        (last_byte_i),
    .out_valid_i        (out_valid_o),
    .out_ready_i        (out_ready_i),
    .speed_centi_kmh_i  (speed_centi_kmh_o),
    .cadence_centi_rpm_i(cadence_centi_rpm_o),
    .speed_updated_i    (speed_updated_o),
    .cadence_updated_i  (cadence_updated_o),
    .packet_short_i     (packet_short_o),
    .fail_count_o       (fail_count),
    .pending_o          (pending)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= WatchdogLimit) begin
      $display("%0t: no transaction for %0d cycles", $time, WatchdogLimit);
      $display("TEST FAILED");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // result side: in idle phases hold ready low for a random count before each transaction
  initial begin : result_sink
    int hold;
    wait (rst_ni);
    forever begin
      if ($urandom_range(0, 31) == 0) out_idle = !out_idle;
      hold = out_idle ? $urandom_range(0, 17) : 0;
      if (hold > 0) begin
        out_ready_i <= 1'b0;
        repeat (hold) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      @(posedge clk_i);
      while (!out_valid_o) @(posedge clk_i);
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic is_first, input logic is_last);
    int gap;
    if ($urandom_range(0, 31) == 0) in_idle = !in_idle;
    gap = in_idle ? $urandom_range(0, 17) : 0;
    // keep valid high across back-to-back transactions
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    data_byte_i <= b;
    first_byte_i <= is_first;
    last_byte_i <= is_last;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
  endtask

  // flags byte, then n_payload bytes: truncated or padded with junk as needed
  task automatic send_packet(input logic [7:0] flags_b, input int n_payload,
                             input bit keep_open);
    logic [7:0] body[$];
    if (flags_b[0]) begin
      for (int i = 0; i < 4; i++) body.push_back(wheel_revs[8*i +: 8]);
      for (int i = 0; i < 2; i++) body.push_back(wheel_evt[8*i +: 8]);
    end
    if (flags_b[1]) begin
      for (int i = 0; i < 2; i++) body.push_back(crank_revs[8*i +: 8]);
      for (int i = 0; i < 2; i++) body.push_back(crank_evt[8*i +: 8]);
    end
    while (body.size() < n_payload) body.push_back(8'($urandom_range(0, 255)));
    send_byte(flags_b, 1'b1, n_payload == 0 && !keep_open);
    for (int i = 0; i < n_payload; i++)
      send_byte(body[i], 1'b0, i == n_payload - 1 && !keep_open);
    sent_bytes += n_payload + 1;
  endtask

  task automatic settle();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_circ(input logic [csc_pkg::CircW-1:0] mm);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= mm;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  initial begin : stimulus
    logic [csc_pkg::CircW-1:0] circ_plan[5];
    logic [7:0]                flags_b;
    int                        pick;
    int                        full;
    int                        n;
    int                        phase_end;
    circ_plan[0] = 12'd0;
    circ_plan[1] = 12'd1;
    circ_plan[2] = 12'd4095;
    circ_plan[3] = 12'd2105;
    circ_plan[4] = 12'($urandom_range(1, 4094));

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    write_circ(12'd4095);
    send_byte(8'h5A, 1'b0, 1'b1);   // stray last byte with no packet open
    send_byte(8'hFC, 1'b1, 1'b1);   // no fields flagged, upper flag bits set
    send_byte(8'h03, 1'b1, 1'b1);   // both fields flagged, none sent
    wheel_revs = '1;
    wheel_evt = '1;
    crank_revs = '1;
    crank_evt = '1;
    send_packet(8'h03, 10, 1'b0);   // largest deltas, both results saturate
    wheel_revs = 32'd1;
    wheel_evt = 16'd0;
    send_packet(8'h01, 6, 1'b0);    // wheel count and time wrap
    send_packet(8'h02, 2, 1'b1);    // abandoned by the next flags byte
    crank_revs = 16'd0;
    crank_evt = 16'd0;
    send_packet(8'h02, 6, 1'b0);    // crank only, trailing bytes
    settle();

    for (int ph = 0; ph < 5; ph++) begin
      write_circ(circ_plan[ph]);
      phase_end = sent_bytes + PhaseBytes;
      while (sent_bytes < phase_end) begin
        pick = $urandom_range(0, 99);
        flags_b = 8'($urandom_range(0, 255));
        if (flags_b[1:0] == 2'b00 && $urandom_range(0, 3) != 0) flags_b[1:0] = 2'b11;
        full = (flags_b[0] ? 6 : 0) + (flags_b[1] ? 4 : 0);

        // advance the sensors; jump now and then to reach every bit
        if ($urandom_range(0, 19) == 0) wheel_revs = $urandom;
        else wheel_revs += $urandom_range(0, 6);
        if ($urandom_range(0, 19) == 0) wheel_evt = 16'($urandom_range(0, 65535));
        else wheel_evt += 16'($urandom_range(0, 3000));
        if ($urandom_range(0, 19) == 0) crank_revs = 16'($urandom_range(0, 65535));
        else crank_revs += 16'($urandom_range(0, 3));
        if ($urandom_range(0, 19) == 0) crank_evt = 16'($urandom_range(0, 65535));
        else crank_evt += 16'($urandom_range(0, 3000));

        if (pick < 70) begin
          n = full + (($urandom_range(0, 7) == 0) ? $urandom_range(1, 6) : 0);
          send_packet(flags_b, n, 1'b0);
        end else if (pick < 80) begin
          n = (full == 0) ? 0 : $urandom_range(0, full - 1);
          send_packet(flags_b, n, 1'b0);
        end else if (pick < 90) begin
          send_packet(flags_b, $urandom_range(0, full + 2), 1'b1);
        end else begin
          send_byte(8'($urandom_range(0, 255)), 1'b0, 1'($urandom_range(0, 1)));
        end
      end
      settle();
    end

    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

FILE: filelist.f
design/csc_pkg.sv
design/csc_parse.sv
design/csc_mul.sv
design/csc_div.sv
design/csc_speed_cadence_decoder.sv
tb/csc_speed_cadence_decoder_chk.sv
tb/csc_speed_cadence_decoder_tb.sv
